// ===== rtl/core/p1305_pkg.sv =====
package p1305_pkg;

    // Field widths of the block.
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned MSG_W   = 129;
    localparam int unsigned ACC_W   = 130;
    localparam int unsigned SUM_W   = 131;
    localparam int unsigned PROD_W  = 256;

    // Limb split of the shared multiplier.
    localparam int unsigned HL_W    = 27;
    localparam int unsigned HL_N    = 5;
    localparam int unsigned RL_W    = 32;
    localparam int unsigned RL_N    = 4;
    localparam int unsigned PP_W    = HL_W + RL_W;
    localparam int unsigned SH_W    = 9;
    localparam int unsigned FULL_BYTES = 16;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_R_LOW  = 8'd0;
    localparam logic [IDX_W-1:0] REG_R_HIGH = 8'd1;
    localparam logic [IDX_W-1:0] REG_S_LOW  = 8'd2;
    localparam logic [IDX_W-1:0] REG_S_HIGH = 8'd3;

    // Clamp masks for the key r.
    localparam logic [WORD_W-1:0] CLAMP_LOW  = 64'h0ffffffc0fffffff;
    localparam logic [WORD_W-1:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    // One classified block as held in the queue.
    typedef struct packed {
        logic [MSG_W-1:0] msg;
        logic             absorb;
        logic             last;
    } t_blk;

    // Queue side seen by the back end.
    typedef struct packed {
        t_blk blk;
        logic vld;
    } t_q_head;

endpackage

// ===== rtl/core/poly1305_mac.sv =====
// Channel   Handshake                      Payload
// block     i_blk_valid / o_blk_stall      i_block_low, i_block_high, i_block_bytes,
//                                          i_last_block
// tag       o_tag_valid / i_tag_stall      o_tag_low, o_tag_high
// config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A block with bytes goes through the back end in order: it is taken from the queue, the 20
// products of the single 27 by 32 bit limb multiplier are issued, the last product drains
// and the folding steps run until the product fits in 130 bits.
// A last block then forms the tag; an empty block skips the limb products.
// Reset is synchronous and active low; it clears keys, accumulator and queue.
// The two-entry queue takes blocks while the back end works or the tag is stalled.
module poly1305_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_blk_valid,
    output logic                         o_blk_stall,
    input  logic [p1305_pkg::WORD_W-1:0] i_block_low,
    input  logic [p1305_pkg::WORD_W-1:0] i_block_high,
    input  logic [p1305_pkg::CNT_W-1:0]  i_block_bytes,
    input  logic                         i_last_block,
    output logic                         o_tag_valid,
    input  logic                         i_tag_stall,
    output logic [p1305_pkg::WORD_W-1:0] o_tag_low,
    output logic [p1305_pkg::WORD_W-1:0] o_tag_high,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [p1305_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [p1305_pkg::WORD_W-1:0] i_cfg_data
);

    p1305_pkg::t_blk    blk;
    p1305_pkg::t_q_head head;
    logic               full;
    logic               pop;

    assign o_cfg_ready = 1'b1;
    assign o_blk_stall = full;

    // Front: byte masking and padding.
    p1305_front u_front (
        .i_block_low   (i_block_low),
        .i_block_high  (i_block_high),
        .i_block_bytes (i_block_bytes),
        .i_last_block  (i_last_block),
        .o_blk         (blk)
    );

    // Queue between front and back.
    p1305_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_blk_valid && !full),
        .i_blk   (blk),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    // Back: modular multiply and tag.
    p1305_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_tag_valid (o_tag_valid),
        .i_tag_stall (i_tag_stall),
        .o_tag_low   (o_tag_low),
        .o_tag_high  (o_tag_high)
    );

endmodule

// ===== rtl/core/p1305_front.sv =====
module p1305_front (
    input  logic [p1305_pkg::WORD_W-1:0] i_block_low,
    input  logic [p1305_pkg::WORD_W-1:0] i_block_high,
    input  logic [p1305_pkg::CNT_W-1:0]  i_block_bytes,
    input  logic                         i_last_block,
    output p1305_pkg::t_blk              o_blk
);

    logic [p1305_pkg::CNT_W-1:0] n_bytes;
    logic [p1305_pkg::MSG_W-1:0] data;
    logic [p1305_pkg::MSG_W-1:0] pad;

    // Counts above sixteen act as a full block; the pad bit sits above the last byte.
    always_comb begin
        n_bytes = (i_block_bytes > p1305_pkg::CNT_W'(p1305_pkg::FULL_BYTES))
                ? p1305_pkg::CNT_W'(p1305_pkg::FULL_BYTES) : i_block_bytes;
        pad  = p1305_pkg::MSG_W'(1) << {n_bytes, 3'b000};
        data = {1'b0, i_block_high, i_block_low};
        o_blk.msg    = (data & (pad - p1305_pkg::MSG_W'(1))) | pad;
        o_blk.absorb = (n_bytes != '0);
        o_blk.last   = i_last_block;
    end

endmodule

// ===== rtl/core/p1305_fifo.sv =====
module p1305_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  p1305_pkg::t_blk   i_blk,
    output logic              o_full,
    input  logic              i_pop,
    output p1305_pkg::t_q_head o_head
);

    p1305_pkg::t_blk r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.vld   = (r_cnt != 2'd0);
    assign o_head.blk   = r_mem[r_rd];

    // Two-entry queue between the front and the back end.
    always_comb begin
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_blk;
        end
    end

endmodule

// ===== rtl/core/p1305_back.sv =====
module p1305_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [p1305_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [p1305_pkg::WORD_W-1:0] i_cfg_data,
    input  p1305_pkg::t_q_head           i_head,
    output logic                         o_pop,
    output logic                         o_tag_valid,
    input  logic                         i_tag_stall,
    output logic [p1305_pkg::WORD_W-1:0] o_tag_low,
    output logic [p1305_pkg::WORD_W-1:0] o_tag_high
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_FOLD = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    logic [p1305_pkg::WORD_W-1:0] r_key_rl, r_key_rh, r_key_sl, r_key_sh;
    logic [p1305_pkg::ACC_W-1:0]  r_acc;
    logic [p1305_pkg::SUM_W-1:0]  r_h;
    logic [p1305_pkg::PROD_W-1:0] r_prod;
    logic [p1305_pkg::PP_W-1:0]   r_pp;
    logic [p1305_pkg::SH_W-1:0]   r_sh;
    logic                         r_pv;
    logic [2:0]                   r_ia;
    logic [1:0]                   r_jr;
    logic                         r_iss_done;
    logic                         r_last;
    logic                         r_out_vld;
    logic [p1305_pkg::WORD_W-1:0] r_tag_lo, r_tag_hi;

    logic [p1305_pkg::HL_N-1:0][p1305_pkg::HL_W-1:0] hl;
    logic [p1305_pkg::RL_N-1:0][p1305_pkg::RL_W-1:0] rl;
    logic [p1305_pkg::SH_W-1:0]   n_sh;
    logic [p1305_pkg::ACC_W:0]    g;
    logic [2*p1305_pkg::WORD_W-1:0] fin;
    logic                         out_free;

    assign o_tag_valid = r_out_vld;
    assign o_tag_low   = r_tag_lo;
    assign o_tag_high  = r_tag_hi;
    assign o_pop       = (r_state == S_IDLE) && i_head.vld;
    assign out_free    = !r_out_vld || !i_tag_stall;

    // Limb views of the sum and of the clamped key.
    always_comb begin
        hl   = (p1305_pkg::HL_N*p1305_pkg::HL_W)'(r_h);
        rl   = {r_key_rh & p1305_pkg::CLAMP_HIGH, r_key_rl & p1305_pkg::CLAMP_LOW};
        n_sh = p1305_pkg::SH_W'(r_ia) * p1305_pkg::SH_W'(p1305_pkg::HL_W)
             + p1305_pkg::SH_W'({r_jr, 5'b00000});
        g    = {1'b0, r_acc} + (p1305_pkg::ACC_W+1)'(5);
        fin  = g[p1305_pkg::ACC_W] ? g[2*p1305_pkg::WORD_W-1:0]
                                   : r_acc[2*p1305_pkg::WORD_W-1:0];
    end

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_rl <= '0;
            r_key_rh <= '0;
            r_key_sl <= '0;
            r_key_sh <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                p1305_pkg::REG_R_LOW:  r_key_rl <= i_cfg_data;
                p1305_pkg::REG_R_HIGH: r_key_rh <= i_cfg_data;
                p1305_pkg::REG_S_LOW:  r_key_sl <= i_cfg_data;
                p1305_pkg::REG_S_HIGH: r_key_sh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: one limb product a cycle, then folding modulo 2^130-5, and the tag for a last block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc      <= '0;
            r_pv       <= 1'b0;
            r_iss_done <= 1'b0;
            r_ia       <= '0;
            r_jr       <= '0;
            r_last     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_out_vld && !i_tag_stall) begin
                r_out_vld <= 1'b0;
            end
            if (r_pv) begin
                r_prod <= r_prod + (p1305_pkg::PROD_W'(r_pp) << r_sh);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.vld) begin
                        r_last <= i_head.blk.last;
                        r_h    <= p1305_pkg::SUM_W'(r_acc)
                                + p1305_pkg::SUM_W'(i_head.blk.msg);
                        r_ia       <= '0;
                        r_jr       <= '0;
                        r_iss_done <= 1'b0;
                        r_pv       <= 1'b0;
                        if (i_head.blk.absorb) begin
                            r_prod  <= '0;
                            r_state <= S_MUL;
                        end else if (i_head.blk.last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    if (r_iss_done) begin
                        r_pv    <= 1'b0;
                        r_state <= S_FOLD;
                    end else begin
                        r_pp <= p1305_pkg::PP_W'(hl[r_ia]) * p1305_pkg::PP_W'(rl[r_jr]);
                        r_sh <= n_sh;
                        r_pv <= 1'b1;
                        r_jr <= r_jr + 2'd1;
                        if (r_jr == 2'd3) begin
                            r_ia <= r_ia + 3'd1;
                            if (r_ia == 3'(p1305_pkg::HL_N - 1)) begin
                                r_iss_done <= 1'b1;
                            end
                        end
                    end
                end
                S_FOLD: begin
                    if (r_prod[p1305_pkg::PROD_W-1:p1305_pkg::ACC_W] == '0) begin
                        r_acc   <= r_prod[p1305_pkg::ACC_W-1:0];
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end else begin
                        r_prod <= p1305_pkg::PROD_W'(r_prod[p1305_pkg::ACC_W-1:0])
                            + p1305_pkg::PROD_W'(r_prod[p1305_pkg::PROD_W-1:p1305_pkg::ACC_W])
                            + (p1305_pkg::PROD_W'(
                               r_prod[p1305_pkg::PROD_W-1:p1305_pkg::ACC_W]) << 2);
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        {r_tag_hi, r_tag_lo} <= fin + {r_key_sh, r_key_sl};
                        r_out_vld <= 1'b1;
                        r_acc     <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
